@@ sv/hsv2rgb_pkg.sv @@
// Package for the HSV to RGB converter: widths, fixed-point constants,
// the hue sector table and the six-sector channel mapping.
// No dependencies; used by hsv_to_rgb.
package hsv2rgb_pkg;

  localparam int unsigned HueW  = 15;
  localparam int unsigned FracW = 9;
  localparam int unsigned ChanW = 8;

  typedef logic [2:0]  sector_t;
  typedef logic [11:0] frac_t;
  typedef logic [11:0] coef_t;
  typedef logic [19:0] scale_t;

  // Hue in 1/64 degree: 23040 is 360 degrees, 3840 is one 60 degree sector.
  localparam logic [HueW-1:0]  HueFull   = 15'd23040;
  localparam logic [FracW-1:0] FracOne   = 9'd256;
  localparam coef_t            SectorLen = 12'd3840;
  localparam scale_t           ScaleOne  = 20'd983040;
  // 4369 / 65536 is just below 1/15; the offset of one in the datapath corrects it.
  localparam logic [12:0]      Recip15   = 13'd4369;
  localparam logic [ChanW-1:0] ChanMax   = 8'd255;

  localparam logic [1:0] ChanRed   = 2'd0;
  localparam logic [1:0] ChanGreen = 2'd1;
  localparam logic [1:0] ChanBlue  = 2'd2;

  // Which of v, q, t or p a channel takes.
  typedef enum logic [1:0] {
    TermV,
    TermQ,
    TermT,
    TermP
  } term_e;

  function automatic logic [HueW-1:0] sector_base(sector_t sec);
    logic [HueW-1:0] base;
    case (sec)
      3'd0:    base = 15'd0;
      3'd1:    base = 15'd3840;
      3'd2:    base = 15'd7680;
      3'd3:    base = 15'd11520;
      3'd4:    base = 15'd15360;
      3'd5:    base = 15'd19200;
      default: base = 15'd0;
    endcase
    return base;
  endfunction

  function automatic term_e chan_term(sector_t sec, logic [1:0] chan);
    term_e r;
    term_e g;
    term_e b;
    case (sec)
      3'd0: begin r = TermV; g = TermT; b = TermP; end
      3'd1: begin r = TermQ; g = TermV; b = TermP; end
      3'd2: begin r = TermP; g = TermV; b = TermT; end
      3'd3: begin r = TermP; g = TermQ; b = TermV; end
      3'd4: begin r = TermT; g = TermP; b = TermV; end
      default: begin r = TermV; g = TermP; b = TermQ; end
    endcase
    if (chan == ChanRed) begin
      return r;
    end else if (chan == ChanGreen) begin
      return g;
    end
    return b;
  endfunction

endpackage

@@ sv/hsv_to_rgb.sv @@
// HSV to RGB converter, five register stages with valid/ready on both sides.
// Depends on hsv2rgb_pkg.
//
// Usage: an item (hue_i, saturation_i, brightness_i) is taken when in_valid_i
// and in_ready_o are both high. The result (red_o, green_o, blue_o,
// out_of_range_o) is offered on out_valid_o and is taken when out_ready_i is
// high. Hue is in 1/64 degree; saturation and brightness are in 1/256 steps
// and are clamped to 1.0. A hue above 360 degrees gives white with
// out_of_range_o set.
//
// Throughput is one item per cycle while the receiver does not stall; the
// stages are hue decode, hue fraction times saturation, brightness times the
// term, scaling by 255, and the division by 15 done by reciprocal multiply.
// Each stage moves on when the next one is empty or moving, so bubbles are
// squeezed out. When the receiver stalls, the result holds and the stages
// fill up; in_ready_o falls only once all five stages hold items.
// Reset empties the pipeline; results in flight are dropped.
module hsv_to_rgb (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hsv2rgb_pkg::HueW-1:0]     hue_i,
  input  logic [hsv2rgb_pkg::FracW-1:0]    saturation_i,
  input  logic [hsv2rgb_pkg::FracW-1:0]    brightness_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]    red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]    green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]    blue_o,
  output logic                             out_of_range_o
);
  import hsv2rgb_pkg::*;

  logic [4:0] vld_q, vld_d;
  logic [4:0] en;

  // Stage 1: decoded hue and clamped fractions.
  logic            oor1_q, oor1_d;
  sector_t         sec1_q, sec1_d;
  frac_t           frac1_q, frac1_d;
  logic [FracW-1:0] sat1_q, sat1_d;
  logic [FracW-1:0] val1_q, val1_d;
  logic [HueW-1:0] hue_eff;

  // Stages 2 to 5, one lane per channel.
  logic             oor2_q, oor3_q, oor4_q;
  logic [FracW-1:0] val2_q;
  scale_t           m2_q[3], m2_d[3];
  logic [27:0]      p3_q[3], p3_d[3];
  logic [11:0]      z4_q[3], z4_d[3];
  logic [ChanW-1:0] ch5_q[3], ch5_d[3];
  logic             oor5_q;

  // Handshake: a stage may load when it is empty or its item moves on.
  always_comb begin
    en[4] = !vld_q[4] || out_ready_i;
    for (int i = 3; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < 5; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1 logic: a hue of exactly 360 degrees folds to zero.
  always_comb begin
    oor1_d  = hue_i > HueFull;
    hue_eff = (hue_i == HueFull) ? '0 : hue_i;
    if (hue_eff >= sector_base(3'd5)) begin
      sec1_d = 3'd5;
    end else if (hue_eff >= sector_base(3'd4)) begin
      sec1_d = 3'd4;
    end else if (hue_eff >= sector_base(3'd3)) begin
      sec1_d = 3'd3;
    end else if (hue_eff >= sector_base(3'd2)) begin
      sec1_d = 3'd2;
    end else if (hue_eff >= sector_base(3'd1)) begin
      sec1_d = 3'd1;
    end else begin
      sec1_d = 3'd0;
    end
    frac1_d = frac_t'(hue_eff - sector_base(sec1_d));
    sat1_d  = (saturation_i > FracOne) ? FracOne : saturation_i;
    val1_d  = (brightness_i > FracOne) ? FracOne : brightness_i;
  end

  // Every term is v * (ScaleOne - k * s), with k chosen by the sector.
  always_comb begin
    coef_t       k;
    logic [20:0] prod;
    for (int c = 0; c < 3; c++) begin
      case (chan_term(sec1_q, 2'(c)))
        TermV:   k = '0;
        TermQ:   k = frac1_q;
        TermT:   k = SectorLen - frac1_q;
        TermP:   k = SectorLen;
        default: k = '0;
      endcase
      prod    = 21'(k) * 21'(sat1_q);
      m2_d[c] = prod[19:0];
    end
  end

  always_comb begin
    scale_t      x;
    logic [28:0] prod;
    for (int c = 0; c < 3; c++) begin
      x       = ScaleOne - m2_q[c];
      prod    = 29'(val2_q) * 29'(x);
      p3_d[c] = prod[27:0];
    end
  end

  // The numerator sits over 2^24 * 15; the power of two is dropped here.
  always_comb begin
    logic [35:0] y;
    for (int c = 0; c < 3; c++) begin
      y       = {p3_q[c], 8'd0} - 36'(p3_q[c]);
      z4_d[c] = y[35:24];
    end
  end

  always_comb begin
    logic [25:0] q;
    logic [9:0]  qq;
    for (int c = 0; c < 3; c++) begin
      q  = 26'(13'(z4_q[c]) + 13'd1) * 26'(Recip15);
      qq = q[25:16];
      if (oor4_q || qq > 10'(ChanMax)) begin
        ch5_d[c] = ChanMax;
      end else begin
        ch5_d[c] = qq[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      oor1_q  <= oor1_d;
      sec1_q  <= sec1_d;
      frac1_q <= frac1_d;
      sat1_q  <= sat1_d;
      val1_q  <= val1_d;
    end
    if (en[1]) begin
      oor2_q <= oor1_q;
      val2_q <= val1_q;
      m2_q   <= m2_d;
    end
    if (en[2]) begin
      oor3_q <= oor2_q;
      p3_q   <= p3_d;
    end
    if (en[3]) begin
      oor4_q <= oor3_q;
      z4_q   <= z4_d;
    end
    if (en[4]) begin
      oor5_q <= oor4_q;
      ch5_q  <= ch5_d;
    end
  end

  assign out_valid_o    = vld_q[4];
  assign red_o          = ch5_q[ChanRed];
  assign green_o        = ch5_q[ChanGreen];
  assign blue_o         = ch5_q[ChanBlue];
  assign out_of_range_o = oor5_q;

  // Input back-pressure only arises from a full pipeline behind a stalled output.
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && (&vld_q)))
    else $error("in_ready_o low without a full, stalled pipeline");

  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !en[2]) |=> vld_q[1])
    else $error("blocked item lost from stage two");

  a_frac_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !oor1_q) |-> (frac1_q < SectorLen && sec1_q <= 3'd5))
    else $error("hue fraction outside its sector");

  a_white : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |->
      (red_o == ChanMax && green_o == ChanMax && blue_o == ChanMax))
    else $error("out of range hue did not give white");

endmodule
